### hdl/siif_pkg.sv
package siif_pkg;

    // core table size, its derived index width and the compare width
    localparam int MAX_CORES = 64;
    localparam int CORE_W    = $clog2(MAX_CORES);
    localparam int CMP_W     = 9;

    // fixed field widths
    localparam int NUM_CORES_W = 7;
    localparam int BOOT_ID_W   = 6;
    localparam int DATA_W      = 32;
    localparam int ID_W        = 8;

    // command low register decode
    localparam logic [DATA_W-1:0] MODE_MASK    = 32'h0000_0F00;
    localparam logic [DATA_W-1:0] MODE_INIT    = 32'h0000_0500;
    localparam logic [DATA_W-1:0] MODE_STARTUP = 32'h0000_0600;
    localparam int                DEST_SHIFT   = 24;

    // configuration register indexes
    localparam logic REG_NUM_CORES = 1'b0;
    localparam logic REG_BOOT_CORE = 1'b1;

    typedef enum logic [2:0] {
        EV_FORWARD = 3'd0,
        EV_INIT    = 3'd1,
        EV_STARTUP = 3'd2,
        EV_DUP     = 3'd3,
        EV_BADDEST = 3'd4,
        EV_READ    = 3'd5
    } t_event;

    typedef struct packed {
        logic              forward;
        logic              forward_is_high;
        logic [DATA_W-1:0] forward_value;
        t_event            event_res;
        logic [ID_W-1:0]   dest_core;
        logic [ID_W-1:0]   start_vector;
        logic              intercept_active;
    } t_result;

    typedef struct packed {
        logic              shadow_we;
        logic              mark;
        logic [CORE_W-1:0] mark_idx;
        logic              release_req;
    } t_update;

endpackage

### hdl/siif_decide.sv
module siif_decide (
    input  logic                               i_is_write,
    input  logic                               i_reg_is_high,
    input  logic [siif_pkg::DATA_W-1:0]        i_write_value,
    input  logic [siif_pkg::DATA_W-1:0]        i_shadow,
    input  logic [siif_pkg::MAX_CORES-1:0]     i_started,
    input  logic                               i_intercept,
    input  logic [siif_pkg::NUM_CORES_W-1:0]   i_num_cores,
    input  logic [siif_pkg::BOOT_ID_W-1:0]     i_boot_core,
    output siif_pkg::t_result                  o_result,
    output siif_pkg::t_update                  o_update
);
    import siif_pkg::*;

    logic [CMP_W-1:0]     present;
    logic [CMP_W-1:0]     num_ext;
    logic [ID_W-1:0]      dest;
    logic                 dest_ok;
    logic [CORE_W-1:0]    dest_idx;
    logic [MAX_CORES-1:0] present_mask;
    logic [MAX_CORES-1:0] boot_mask;
    logic [MAX_CORES-1:0] mark_mask;
    logic [MAX_CORES-1:0] next_started;
    logic                 all_started;
    logic                 is_init;
    logic                 is_startup;

    // effective core count, saturated at the table size
    assign num_ext = CMP_W'(i_num_cores);
    assign present = (num_ext > CMP_W'(MAX_CORES)) ? CMP_W'(MAX_CORES) : num_ext;

    // destination from the shadowed high register
    assign dest     = i_shadow[DEST_SHIFT +: ID_W];
    assign dest_ok  = (CMP_W'(dest) < present);
    assign dest_idx = dest[CORE_W-1:0];

    assign is_init    = ((i_write_value & MODE_MASK) == MODE_INIT);
    assign is_startup = ((i_write_value & MODE_MASK) == MODE_STARTUP);

    // per-core masks for the release check
    always_comb begin
        for (int i = 0; i < MAX_CORES; i++) begin
            present_mask[i] = (CMP_W'(i) < present);
            boot_mask[i]    = (CMP_W'(i) == CMP_W'(i_boot_core));
            mark_mask[i]    = (CORE_W'(i) == dest_idx);
        end
    end

    assign next_started = i_started | mark_mask;
    assign all_started  = &(next_started | ~present_mask | boot_mask);

    // access classification
    always_comb begin
        o_result = '0;
        o_update = '0;
        o_update.mark_idx = dest_idx;
        o_result.event_res = EV_FORWARD;
        if (!i_is_write) begin
            o_result.event_res = EV_READ;
        end else if (i_reg_is_high) begin
            o_update.shadow_we        = 1'b1;
            o_result.forward          = 1'b1;
            o_result.forward_is_high  = 1'b1;
            o_result.forward_value    = i_write_value;
        end else if (!i_intercept) begin
            o_result.forward       = 1'b1;
            o_result.forward_value = i_write_value;
        end else if (is_init) begin
            o_result.event_res = EV_INIT;
        end else if (is_startup) begin
            o_result.dest_core = dest;
            if (!dest_ok) begin
                o_result.event_res = EV_BADDEST;
            end else begin
                if (i_started[dest_idx]) begin
                    o_result.event_res = EV_DUP;
                end else begin
                    o_result.event_res    = EV_STARTUP;
                    o_result.start_vector = i_write_value[ID_W-1:0];
                    o_update.mark         = 1'b1;
                end
                o_update.release_req = all_started;
            end
        end else begin
            o_result.forward       = 1'b1;
            o_result.forward_value = i_write_value;
        end
        o_result.intercept_active = i_intercept & ~o_update.release_req;
    end

endmodule

### hdl/startup_ipi_intercept_filter_unit.sv
// datapath: input register, decision logic, result register; throughput: one word
// per cycle without result stalls; input and result registers each hold one word,
// so while a result waits the input side takes one more word and then stalls
// reset (synchronous, active low): pipeline empty, shadow and started table clear,
// interception on, core count 1, boot core 0
module startup_ipi_intercept_filter_unit (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // input channel
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  logic                             i_is_write,
    input  logic                             i_reg_is_high,
    input  logic [siif_pkg::DATA_W-1:0]      i_write_value,
    // result channel
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output logic                             o_forward,
    output logic                             o_forward_is_high,
    output logic [siif_pkg::DATA_W-1:0]      o_forward_value,
    output logic [2:0]                       o_event_res,
    output logic [siif_pkg::ID_W-1:0]        o_dest_core,
    output logic [siif_pkg::ID_W-1:0]        o_start_vector,
    output logic                             o_intercept_active,
    // configuration port
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [2:0]                       paddr,
    input  logic [31:0]                      pwdata,
    output logic [31:0]                      prdata,
    output logic                             pready
);
    import siif_pkg::*;

    logic                   r_in_valid;
    logic                   r_in_is_write;
    logic                   r_in_reg_is_high;
    logic [DATA_W-1:0]      r_in_value;
    logic                   r_out_valid;
    t_result                r_out;
    logic [DATA_W-1:0]      r_shadow;
    logic [MAX_CORES-1:0]   r_started;
    logic                   r_intercept;
    logic [NUM_CORES_W-1:0] r_num_cores;
    logic [BOOT_ID_W-1:0]   r_boot_core;

    logic                   advance;
    logic                   in_take;
    logic                   cfg_we;
    t_result                n_out;
    t_update                upd;

    // pipeline flow control
    assign advance    = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !advance;
    assign in_take    = i_in_valid && !o_in_stall;

    // decision logic
    siif_decide u_decide (
        .i_is_write    (r_in_is_write),
        .i_reg_is_high (r_in_reg_is_high),
        .i_write_value (r_in_value),
        .i_shadow      (r_shadow),
        .i_started     (r_started),
        .i_intercept   (r_intercept),
        .i_num_cores   (r_num_cores),
        .i_boot_core   (r_boot_core),
        .o_result      (n_out),
        .o_update      (upd)
    );

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_is_write    <= i_is_write;
            r_in_reg_is_high <= i_reg_is_high;
            r_in_value       <= i_write_value;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= n_out;
        end
    end

    // filter state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_shadow    <= '0;
            r_started   <= '0;
            r_intercept <= 1'b1;
        end else if (advance) begin
            if (upd.shadow_we) begin
                r_shadow <= r_in_value;
            end
            if (upd.mark) begin
                r_started[upd.mark_idx] <= 1'b1;
            end
            if (upd.release_req) begin
                r_intercept <= 1'b0;
            end
        end
    end

    // configuration registers
    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_cores <= NUM_CORES_W'(1);
            r_boot_core <= '0;
        end else if (cfg_we) begin
            unique case (paddr[2])
                REG_NUM_CORES: r_num_cores <= pwdata[NUM_CORES_W-1:0];
                REG_BOOT_CORE: r_boot_core <= pwdata[BOOT_ID_W-1:0];
                default:       r_num_cores <= r_num_cores;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_NUM_CORES: prdata = 32'(r_num_cores);
            REG_BOOT_CORE: prdata = 32'(r_boot_core);
            default:       prdata = '0;
        endcase
    end

    // result ports
    assign o_out_valid        = r_out_valid;
    assign o_forward          = r_out.forward;
    assign o_forward_is_high  = r_out.forward_is_high;
    assign o_forward_value    = r_out.forward_value;
    assign o_event_res        = r_out.event_res;
    assign o_dest_core        = r_out.dest_core;
    assign o_start_vector     = r_out.start_vector;
    assign o_intercept_active = r_out.intercept_active;

`ifndef SYNTH
    // interception never comes back on without reset
    a_release_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_intercept |=> !r_intercept)
        else $error("interception re-enabled after release");

    // a delivered startup marks its destination in the table
    a_mark_set: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && upd.mark) |=> r_started[$past(upd.mark_idx)])
        else $error("startup destination not marked");

    // the result word's intercept flag follows the state after that word
    a_active_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance |=> (r_out.intercept_active == r_intercept))
        else $error("intercept_active disagrees with state");

    // reads and init commands never forward
    a_no_fwd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out.event_res == EV_READ || r_out.event_res == EV_INIT))
            |-> !r_out.forward)
        else $error("forward set on a non-forwarded event");
`endif

endmodule

### tb/sv/startup_ipi_intercept_filter_unit_tb.sv
`timescale 1ns / 100ps

module startup_ipi_intercept_filter_unit_tb;
    import siif_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 4;
    localparam int MAX_REPORTS  = 10;
    localparam int NUM_PHASES   = 5;

    // one guest access to the command registers
    typedef struct packed {
        logic              is_write;
        logic              reg_is_high;
        logic [DATA_W-1:0] value;
    } t_access;

    // directed row: either a register write or an access word
    typedef struct packed {
        logic              is_cfg;
        logic              cfg_reg;
        logic [31:0]       cfg_val;
        t_access           acc;
        logic              typed;
        t_result           res;
    } t_row;

    // dut signals, all inputs known from time zero
    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_in_valid = 1'b0;
    logic              o_in_stall;
    logic              i_is_write = 1'b0;
    logic              i_reg_is_high = 1'b0;
    logic [DATA_W-1:0] i_write_value = '0;
    logic              o_out_valid;
    logic              i_out_stall = 1'b0;
    logic              o_forward;
    logic              o_forward_is_high;
    logic [DATA_W-1:0] o_forward_value;
    logic [2:0]        o_event_res;
    logic [ID_W-1:0]   o_dest_core;
    logic [ID_W-1:0]   o_start_vector;
    logic              o_intercept_active;
    logic              psel = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite = 1'b0;
    logic [2:0]        paddr = '0;
    logic [31:0]       pwdata = '0;
    logic [31:0]       prdata;
    logic              pready;

    // predictor copy of the block state and its configuration
    logic [NUM_CORES_W-1:0] cfg_num_cores = 7'd1;
    logic [BOOT_ID_W-1:0]   cfg_boot_id = '0;
    logic [DATA_W-1:0]      icr_hi_shadow = '0;
    logic [MAX_CORES-1:0]   core_up = '0;
    logic                   intercepting = 1'b1;

    t_result pending_results[$];
    t_access stim_q[$];
    t_row    dir_rows[$];
    int      mismatch_count = 0;
    int      cycle_count = 0;
    int      burst_left = 0;
    int      stall_mode = 0;
    int      stall_span = 0;
    logic    stall_toggle = 1'b0;

    int phase_cores[NUM_PHASES] = '{127, 0, 64, 20, 64};
    int phase_boot[NUM_PHASES]  = '{17, 63, 0, 63, 63};
    int phase_words[NUM_PHASES] = '{600, 200, 350, 150, 530};
    int phase_dest[NUM_PHASES]  = '{39, 255, 50, 25, 255};

    startup_ipi_intercept_filter_unit u_dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_in_valid         (i_in_valid),
        .o_in_stall         (o_in_stall),
        .i_is_write         (i_is_write),
        .i_reg_is_high      (i_reg_is_high),
        .i_write_value      (i_write_value),
        .o_out_valid        (o_out_valid),
        .i_out_stall        (i_out_stall),
        .o_forward          (o_forward),
        .o_forward_is_high  (o_forward_is_high),
        .o_forward_value    (o_forward_value),
        .o_event_res        (o_event_res),
        .o_dest_core        (o_dest_core),
        .o_start_vector     (o_start_vector),
        .o_intercept_active (o_intercept_active),
        .psel               (psel),
        .penable            (penable),
        .pwrite             (pwrite),
        .paddr              (paddr),
        .pwdata             (pwdata),
        .prdata             (prdata),
        .pready             (pready)
    );

    // clock
    always #5 i_clk = ~i_clk;

    // run limit
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // filter decision for one access, updates the shadow, started table and interception state
    function automatic t_result filter_icr_access(input t_access a);
        t_result         r;
        int unsigned     present;
        logic [ID_W-1:0] dest;
        logic            all_up;
        r = '0;
        r.event_res = EV_FORWARD;
        present = (cfg_num_cores > MAX_CORES) ? MAX_CORES : cfg_num_cores;
        if (!a.is_write) begin
            r.event_res = EV_READ;
        end else if (a.reg_is_high) begin
            icr_hi_shadow = a.value;
            r.forward = 1'b1;
            r.forward_is_high = 1'b1;
            r.forward_value = a.value;
        end else if (!intercepting) begin
            r.forward = 1'b1;
            r.forward_value = a.value;
        end else if ((a.value & MODE_MASK) == MODE_INIT) begin
            r.event_res = EV_INIT;
        end else if ((a.value & MODE_MASK) == MODE_STARTUP) begin
            // destination always comes from the shadow, shorthand ignored
            dest = icr_hi_shadow[DATA_W-1:DEST_SHIFT];
            r.dest_core = dest;
            if (dest >= present) begin
                r.event_res = EV_BADDEST;
            end else begin
                if (core_up[dest]) begin
                    r.event_res = EV_DUP;
                end else begin
                    r.event_res = EV_STARTUP;
                    r.start_vector = a.value[7:0];
                    core_up[dest] = 1'b1;
                end
                // release once every present core but the boot core is up
                all_up = 1'b1;
                for (int i = 0; i < present; i++) begin
                    if (i != cfg_boot_id && !core_up[i])
                        all_up = 1'b0;
                end
                if (all_up)
                    intercepting = 1'b0;
            end
        end else begin
            r.forward = 1'b1;
            r.forward_value = a.value;
        end
        r.intercept_active = intercepting;
        return r;
    endfunction

    // typed expectations for directed rows
    function automatic t_result r_fwd(input logic hi, input logic [DATA_W-1:0] val);
        t_result r;
        r = '0;
        r.forward = 1'b1;
        r.forward_is_high = hi;
        r.forward_value = val;
        r.event_res = EV_FORWARD;
        r.intercept_active = 1'b1;
        return r;
    endfunction

    function automatic t_result r_drop(input t_event ev, input logic [ID_W-1:0] dest,
                                       input logic [ID_W-1:0] vec);
        t_result r;
        r = '0;
        r.event_res = ev;
        r.dest_core = dest;
        r.start_vector = vec;
        r.intercept_active = 1'b1;
        return r;
    endfunction

    function automatic t_row row_word_exp(input logic w, input logic hi,
                                          input logic [DATA_W-1:0] val, input t_result r);
        t_row row;
        row = '0;
        row.acc.is_write = w;
        row.acc.reg_is_high = hi;
        row.acc.value = val;
        row.typed = 1'b1;
        row.res = r;
        return row;
    endfunction

    function automatic t_row row_word(input logic w, input logic hi,
                                      input logic [DATA_W-1:0] val);
        t_row row;
        row = row_word_exp(w, hi, val, '0);
        row.typed = 1'b0;
        return row;
    endfunction

    function automatic t_row row_cfg(input logic idx, input logic [31:0] val);
        t_row row;
        row = '0;
        row.is_cfg = 1'b1;
        row.cfg_reg = idx;
        row.cfg_val = val;
        return row;
    endfunction

    // directed words: extremes, every event and the corner cases
    task load_directed();
        // reset config: one core, boot core 0
        dir_rows.push_back(row_word_exp(1'b0, 1'b0, 32'hFFFF_FFFF, r_drop(EV_READ, 0, 0)));
        dir_rows.push_back(row_word_exp(1'b0, 1'b1, 32'h0000_0000, r_drop(EV_READ, 0, 0)));
        dir_rows.push_back(row_word_exp(1'b1, 1'b1, 32'hFF00_0000, r_fwd(1'b1, 32'hFF00_0000)));
        dir_rows.push_back(row_word_exp(1'b1, 1'b0, 32'h0000_0500, r_drop(EV_INIT, 0, 0)));
        dir_rows.push_back(row_word_exp(1'b1, 1'b0, 32'hFFFF_F5FF, r_drop(EV_INIT, 0, 0)));
        dir_rows.push_back(row_word_exp(1'b1, 1'b0, 32'h0000_06AB,
                                        r_drop(EV_BADDEST, 8'hFF, 0)));
        dir_rows.push_back(row_word_exp(1'b1, 1'b0, 32'h0000_0400, r_fwd(1'b0, 32'h0000_0400)));
        dir_rows.push_back(row_word_exp(1'b1, 1'b0, 32'hFFFF_FFFF, r_fwd(1'b0, 32'hFFFF_FFFF)));
        dir_rows.push_back(row_word_exp(1'b1, 1'b0, 32'h0000_0000, r_fwd(1'b0, 32'h0000_0000)));
        // full core set, boot core at the top id
        dir_rows.push_back(row_cfg(REG_NUM_CORES, 32'd64));
        dir_rows.push_back(row_cfg(REG_BOOT_CORE, 32'd63));
        dir_rows.push_back(row_word_exp(1'b1, 1'b1, 32'h0000_0000, r_fwd(1'b1, 32'h0000_0000)));
        dir_rows.push_back(row_word_exp(1'b1, 1'b0, 32'h0000_06FF,
                                        r_drop(EV_STARTUP, 0, 8'hFF)));
        dir_rows.push_back(row_word_exp(1'b1, 1'b0, 32'h0000_0600, r_drop(EV_DUP, 0, 0)));
        // startup to the boot core with shorthand bits set
        dir_rows.push_back(row_word(1'b1, 1'b1, 32'h3FFF_FFFF));
        dir_rows.push_back(row_word(1'b1, 1'b0, 32'h000C_0600));
        // first id past the present cores
        dir_rows.push_back(row_word(1'b1, 1'b1, 32'h4000_0000));
        dir_rows.push_back(row_word(1'b1, 1'b0, 32'h0000_0612));
        // core count above the table size clamps
        dir_rows.push_back(row_cfg(REG_NUM_CORES, 32'd127));
        dir_rows.push_back(row_word(1'b1, 1'b1, 32'h3E00_0000));
        dir_rows.push_back(row_word(1'b1, 1'b0, 32'hFFFF_F6A5));
        // no core present at all
        dir_rows.push_back(row_cfg(REG_NUM_CORES, 32'd0));
        dir_rows.push_back(row_word(1'b1, 1'b1, 32'h0012_3456));
        dir_rows.push_back(row_word(1'b1, 1'b0, 32'h0000_065A));
        dir_rows.push_back(row_word(1'b0, 1'b0, 32'h0000_0600));
    endtask

    // random words, mostly shadow write followed by a startup
    task gen_words(input int count, input int dest_hi);
        int              sel;
        t_access         a;
        logic [ID_W-1:0] d;
        stim_q.delete();
        while (stim_q.size() < count) begin
            sel = $urandom_range(0, 99);
            a.is_write = 1'b1;
            a.reg_is_high = 1'b0;
            a.value = $urandom;
            if (sel < 40) begin
                d = ($urandom_range(0, 9) < 7) ? 8'($urandom_range(0, dest_hi))
                                               : 8'($urandom_range(0, 255));
                a.reg_is_high = 1'b1;
                a.value = {d, a.value[23:0]};
                stim_q.push_back(a);
                a.reg_is_high = 1'b0;
                a.value = ($urandom & ~MODE_MASK) | MODE_STARTUP;
            end else if (sel < 50) begin
                a.value = (a.value & ~MODE_MASK) | MODE_STARTUP;
            end else if (sel < 60) begin
                a.value = (a.value & ~MODE_MASK) | MODE_INIT;
            end else if (sel < 75) begin
                // low write with whatever mode the bits give
            end else if (sel < 85) begin
                a.reg_is_high = 1'b1;
            end else begin
                a.is_write = 1'b0;
                a.reg_is_high = 1'($urandom_range(0, 1));
            end
            stim_q.push_back(a);
        end
    endtask

    // wait until every expected result word has been taken
    task wait_drained();
        while (pending_results.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // config register write, only with the pipeline empty
    task write_reg(input logic idx, input logic [31:0] val);
        wait_drained();
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (idx == REG_NUM_CORES)
            cfg_num_cores = val[NUM_CORES_W-1:0];
        else
            cfg_boot_id = val[BOOT_ID_W-1:0];
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    // present one word and hold it until accepted; bursts with gaps between
    task send_word(input t_access a, input logic last, input logic use_typed,
                   input t_result typed_res);
        t_result pred;
        if (!i_in_valid)
            i_in_valid <= 1'b1;
        i_is_write <= a.is_write;
        i_reg_is_high <= a.reg_is_high;
        i_write_value <= a.value;
        do @(posedge i_clk); while (o_in_stall);
        pred = filter_icr_access(a);
        pending_results.push_back(use_typed ? typed_res : pred);
        if (last || burst_left == 0) begin
            i_in_valid <= 1'b0;
            if (!last)
                repeat ($urandom_range(1, 6)) @(posedge i_clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                      : $urandom_range(0, 8);
        end else begin
            burst_left--;
        end
    endtask

    // compare one accepted result word with the oldest expectation
    task check_result();
        t_result want;
        if (pending_results.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS)
                $display("unexpected result word: fwd=%0b ev=%0d val=%08h",
                         o_forward, o_event_res, o_forward_value);
        end else begin
            want = pending_results.pop_front();
            if (o_forward !== want.forward || o_forward_is_high !== want.forward_is_high
                || o_forward_value !== want.forward_value
                || o_event_res !== want.event_res || o_dest_core !== want.dest_core
                || o_start_vector !== want.start_vector
                || o_intercept_active !== want.intercept_active) begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS) begin
                    $display("mismatch exp: fwd=%0b hi=%0b val=%08h ev=%0d dest=%02h vec=%02h act=%0b",
                             want.forward, want.forward_is_high, want.forward_value,
                             want.event_res, want.dest_core, want.start_vector,
                             want.intercept_active);
                    $display("         got: fwd=%0b hi=%0b val=%08h ev=%0d dest=%02h vec=%02h act=%0b",
                             o_forward, o_forward_is_high, o_forward_value, o_event_res,
                             o_dest_core, o_start_vector, o_intercept_active);
                end
            end
        end
    endtask

    // result side: check taken words, then pick the next stall
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall)
            check_result();
        if (stall_span == 0) begin
            stall_mode = $urandom_range(0, 3);
            stall_span = $urandom_range(10, 80);
        end else begin
            stall_span--;
        end
        stall_toggle = ~stall_toggle;
        case (stall_mode)
            0: i_out_stall <= 1'b0;
            1: i_out_stall <= ($urandom_range(0, 3) == 0);
            2: i_out_stall <= ($urandom_range(0, 3) != 0);
            default: i_out_stall <= stall_toggle;
        endcase
    end

    // stimulus
    initial begin
        load_directed();
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed table
        for (int i = 0; i < dir_rows.size(); i++) begin
            if (dir_rows[i].is_cfg)
                write_reg(dir_rows[i].cfg_reg, dir_rows[i].cfg_val);
            else
                send_word(dir_rows[i].acc,
                          (i == dir_rows.size() - 1) || dir_rows[i + 1].is_cfg,
                          dir_rows[i].typed, dir_rows[i].res);
        end

        // random phases under several core settings
        for (int p = 0; p < NUM_PHASES; p++) begin
            write_reg(REG_NUM_CORES, 32'(phase_cores[p]));
            write_reg(REG_BOOT_CORE, 32'(phase_boot[p]));
            gen_words(phase_words[p], phase_dest[p]);
            for (int i = 0; i < stim_q.size(); i++)
                send_word(stim_q[i], i == stim_q.size() - 1, 1'b0, '0);
        end

        wait_drained();
        if (mismatch_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
